// ----- sv/s2b_pkg.sv -----
// Package with shared types and helpers for the spline to Bezier segment converter.
`default_nettype none
package s2b_pkg;

	// Phase of the spline being taken: no point yet, one point, two or more points.
	typedef enum logic [1:0] {
		PH_EMPTY = 2'd0,
		PH_ONE   = 2'd1,
		PH_MANY  = 2'd2
	} s2b_phase_t;

	typedef struct packed {
		logic signed [31:0] ctrl1_x;
		logic signed [31:0] ctrl1_y;
		logic signed [31:0] ctrl2_x;
		logic signed [31:0] ctrl2_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic               too_few_points;
		logic               final_segment;
	} s2b_seg_t;

	typedef struct packed {
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic               last_point;
	} s2b_point_t;

	// Halve, truncating toward zero: add the sign bit, then shift arithmetically.
	function automatic logic signed [31:0] half32(input logic signed [31:0] v);
		logic signed [31:0] t;
		t = v + {31'd0, v[31]};
		return t >>> 1;
	endfunction

endpackage
`default_nettype wire

// ----- sv/s2b_point_if.sv -----
// Input channel carrying one displacement item per handshake.
`default_nettype none
interface s2b_point_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic               last_point;

	modport source (output valid, delta_x, delta_y, last_point, input ready);
	modport sink   (input valid, delta_x, delta_y, last_point, output ready);
endinterface
`default_nettype wire

// ----- sv/s2b_seg_if.sv -----
// Output channel carrying one Bezier segment item per handshake.
`default_nettype none
interface s2b_seg_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] ctrl1_x;
	logic signed [31:0] ctrl1_y;
	logic signed [31:0] ctrl2_x;
	logic signed [31:0] ctrl2_y;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic               too_few_points;
	logic               final_segment;

	modport source (output valid, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
		too_few_points, final_segment, input ready);
	modport sink   (input valid, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
		too_few_points, final_segment, output ready);
endinterface
`default_nettype wire

// ----- sv/s2b_calc.sv -----
// Spline state and the segment arithmetic for one point.
`default_nettype none
module s2b_calc (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              apply,
	input  wire s2b_pkg::s2b_point_t point,
	output logic                   has_result,
	output s2b_pkg::s2b_seg_t      seg
);

	s2b_pkg::s2b_phase_t phase_q, phase_d;
	logic signed [31:0]  prev_x_q, prev_y_q, pen_x_q, pen_y_q;
	logic signed [31:0]  prev_x_d, prev_y_d, pen_x_d, pen_y_d;

	logic signed [31:0] dx, dy, dxa, dya, px, py, mx, my;

	always_comb begin
		dx  = {{16{point.delta_x[15]}}, point.delta_x};
		dy  = {{16{point.delta_y[15]}}, point.delta_y};
		// take one extra unit off a negative displacement
		dxa = dx - {31'd0, dx[31]};
		dya = dy - {31'd0, dy[31]};
		px  = prev_x_q + dxa;
		py  = prev_y_q + dya;
		mx  = s2b_pkg::half32(prev_x_q + px);
		my  = s2b_pkg::half32(prev_y_q + py);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= s2b_pkg::PH_EMPTY;
			prev_x_q <= '0;
			prev_y_q <= '0;
			pen_x_q  <= '0;
			pen_y_q  <= '0;
		end else if (apply) begin
			phase_q  <= phase_d;
			prev_x_q <= prev_x_d;
			prev_y_q <= prev_y_d;
			pen_x_q  <= pen_x_d;
			pen_y_q  <= pen_y_d;
		end
	end

	always_comb begin
		phase_d    = s2b_pkg::PH_MANY;
		prev_x_d   = px;
		prev_y_d   = py;
		pen_x_d    = mx;
		pen_y_d    = my;
		has_result = 1'b1;
		seg        = '0;
		seg.final_segment = point.last_point;
		unique case (phase_q)
			s2b_pkg::PH_EMPTY: begin
				prev_x_d = dx;
				prev_y_d = dy;
				pen_x_d  = '0;
				pen_y_d  = '0;
				phase_d  = s2b_pkg::PH_ONE;
				has_result = point.last_point;
				seg.too_few_points = point.last_point;
			end
			s2b_pkg::PH_ONE: begin
				seg.ctrl1_x = s2b_pkg::half32(prev_x_q);
				seg.ctrl1_y = -s2b_pkg::half32(prev_y_q);
				if (point.last_point) begin
					seg.ctrl2_x = mx;
					seg.ctrl2_y = -my;
					seg.end_x   = px;
					seg.end_y   = -py;
				end else begin
					seg.ctrl2_x = prev_x_q;
					seg.ctrl2_y = -prev_y_q;
					seg.end_x   = mx;
					seg.end_y   = -my;
				end
			end
			default: begin
				seg.ctrl1_x = prev_x_q - pen_x_q;
				seg.ctrl1_y = pen_y_q - prev_y_q;
				if (point.last_point) begin
					seg.ctrl2_x = mx - pen_x_q;
					seg.ctrl2_y = pen_y_q - my;
					seg.end_x   = px - pen_x_q;
					seg.end_y   = pen_y_q - py;
				end else begin
					seg.ctrl2_x = prev_x_q - pen_x_q;
					seg.ctrl2_y = pen_y_q - prev_y_q;
					seg.end_x   = mx - pen_x_q;
					seg.end_y   = pen_y_q - my;
				end
			end
		endcase
		// end of spline: return to the reset state
		if (point.last_point) begin
			phase_d  = s2b_pkg::PH_EMPTY;
			prev_x_d = '0;
			prev_y_d = '0;
			pen_x_d  = '0;
			pen_y_d  = '0;
		end
	end

endmodule
`default_nettype wire

// ----- sv/spline_to_bezier_segments.sv -----
// Top level of the spline to Bezier segment converter.
// Takes one relative displacement item per cycle while the sink keeps up, and gives at
// most one relative cubic Bezier segment item for it. An item passes an input register,
// the segment arithmetic against the spline state, and an output register, where the
// segment is valid until the sink takes it; one item per cycle is sustained while the
// sink is ready. The output register holds a segment while the sink stalls; items that
// give no segment (the first point of a spline of two or more points) retire without
// waiting on the output side.
`default_nettype none
module spline_to_bezier_segments (
	input  wire logic clk,
	input  wire logic arst_n,
	s2b_point_if.sink points,
	s2b_seg_if.source segments
);

	logic                valid_s1;
	s2b_pkg::s2b_point_t point_s1;
	logic                has_result;
	s2b_pkg::s2b_seg_t   seg_calc;
	s2b_pkg::s2b_seg_t   seg_q;
	logic                out_valid_q;
	logic                advance;

	assign advance = valid_s1 && (!has_result || !out_valid_q || segments.ready);
	assign points.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (points.ready) begin
			valid_s1 <= points.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (points.ready && points.valid) begin
			point_s1.delta_x    <= points.delta_x;
			point_s1.delta_y    <= points.delta_y;
			point_s1.last_point <= points.last_point;
		end
	end

	s2b_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.apply      (advance),
		.point      (point_s1),
		.has_result (has_result),
		.seg        (seg_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (segments.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			seg_q <= seg_calc;
		end
	end

	assign segments.valid          = out_valid_q;
	assign segments.ctrl1_x        = seg_q.ctrl1_x;
	assign segments.ctrl1_y        = seg_q.ctrl1_y;
	assign segments.ctrl2_x        = seg_q.ctrl2_x;
	assign segments.ctrl2_y        = seg_q.ctrl2_y;
	assign segments.end_x          = seg_q.end_x;
	assign segments.end_y          = seg_q.end_y;
	assign segments.too_few_points = seg_q.too_few_points;
	assign segments.final_segment  = seg_q.final_segment;

endmodule
`default_nettype wire

// ----- tb/s2b_seg_scoreboard_pkg.sv -----
// Scoreboard class that predicts and checks Bezier segment items for the spline converter.
`timescale 1ns / 100ps
package s2b_seg_scoreboard_pkg;
	import s2b_pkg::*;

	class seg_scoreboard;
		s2b_phase_t  phase;
		logic [31:0] prev_x;
		logic [31:0] prev_y;
		logic [31:0] pen_x;
		logic [31:0] pen_y;
		s2b_seg_t    expected_segs[$];
		int          mismatches;

		function new();
			restart_spline();
			mismatches = 0;
		endfunction

		function void restart_spline();
			phase  = PH_EMPTY;
			prev_x = '0;
			prev_y = '0;
			pen_x  = '0;
			pen_y  = '0;
		endfunction

		// Halve toward zero: shift the magnitude, then restore the sign.
		static function logic [31:0] halve(logic [31:0] v);
			logic [31:0] mag;
			if (v[31]) begin
				mag = -v;
				mag = mag >> 1;
				return -mag;
			end
			return v >> 1;
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		// Predict the segment, if any, for one accepted point item.
		function void note_point(s2b_point_t p);
			logic [31:0] dx;
			logic [31:0] dy;
			logic [31:0] px;
			logic [31:0] py;
			logic [31:0] mx;
			logic [31:0] my;
			logic [31:0] jx;
			logic [31:0] jy;
			s2b_seg_t    seg;
			dx  = {{16{p.delta_x[15]}}, p.delta_x};
			dy  = {{16{p.delta_y[15]}}, p.delta_y};
			seg = '0;
			if (phase == PH_EMPTY) begin
				prev_x = dx;
				prev_y = dy;
				if (p.last_point) begin
					seg.too_few_points = 1'b1;
					seg.final_segment  = 1'b1;
					expected_segs.push_back(seg);
					restart_spline();
				end else begin
					phase = PH_ONE;
				end
			end else begin
				// Take one extra unit off each negative displacement.
				if (dx[31])
					dx = dx - 32'd1;
				if (dy[31])
					dy = dy - 32'd1;
				px = prev_x + dx;
				py = prev_y + dy;
				mx = halve(prev_x + px);
				my = halve(prev_y + py);
				if (phase == PH_ONE) begin
					seg.ctrl1_x = halve(prev_x);
					seg.ctrl1_y = -halve(prev_y);
					if (p.last_point) begin
						seg.ctrl2_x = mx;
						seg.ctrl2_y = -my;
						seg.end_x   = px;
						seg.end_y   = -py;
					end else begin
						seg.ctrl2_x = prev_x;
						seg.ctrl2_y = -prev_y;
						seg.end_x   = mx;
						seg.end_y   = -my;
					end
				end else begin
					jx = prev_x - pen_x;
					jy = pen_y - prev_y;
					seg.ctrl1_x = jx;
					seg.ctrl1_y = jy;
					if (p.last_point) begin
						seg.ctrl2_x = mx - pen_x;
						seg.ctrl2_y = pen_y - my;
						seg.end_x   = px - pen_x;
						seg.end_y   = pen_y - py;
					end else begin
						seg.ctrl2_x = jx;
						seg.ctrl2_y = jy;
						seg.end_x   = mx - pen_x;
						seg.end_y   = pen_y - my;
					end
				end
				seg.final_segment = p.last_point;
				expected_segs.push_back(seg);
				if (p.last_point) begin
					restart_spline();
				end else begin
					pen_x  = mx;
					pen_y  = my;
					prev_x = px;
					prev_y = py;
					phase  = PH_MANY;
				end
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got)
				note_mismatch($sformatf("%s expected %0d (0x%08h) got %0d (0x%08h)",
					name, $signed(want), want, $signed(got), got));
		endfunction

		function void check_segment(s2b_seg_t got);
			s2b_seg_t want;
			if (expected_segs.size() == 0) begin
				note_mismatch($sformatf("segment with none expected: %p", got));
				return;
			end
			want = expected_segs.pop_front();
			compare_field("ctrl1_x", want.ctrl1_x, got.ctrl1_x);
			compare_field("ctrl1_y", want.ctrl1_y, got.ctrl1_y);
			compare_field("ctrl2_x", want.ctrl2_x, got.ctrl2_x);
			compare_field("ctrl2_y", want.ctrl2_y, got.ctrl2_y);
			compare_field("end_x", want.end_x, got.end_x);
			compare_field("end_y", want.end_y, got.end_y);
			compare_field("too_few_points", {31'd0, want.too_few_points},
				{31'd0, got.too_few_points});
			compare_field("final_segment", {31'd0, want.final_segment},
				{31'd0, got.final_segment});
		endfunction

		function int pending();
			return expected_segs.size();
		endfunction
	endclass

endpackage

// ----- tb/spline_to_bezier_segments_tb.sv -----
// Testbench top for the spline to Bezier segment converter: random splines, random stalls.
`timescale 1ns / 100ps
module spline_to_bezier_segments_tb;
	import s2b_pkg::*;
	import s2b_seg_scoreboard_pkg::*;

	localparam int NUM_ITEMS   = 800;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_TAIL  = 10;

	logic clk;
	logic arst_n;
	bit   tx_idle;
	bit   rx_idle;
	int   items_sent;
	int   idle_cycles;

	seg_scoreboard sb;

	s2b_point_if points_if();
	s2b_seg_if   segs_if();

	spline_to_bezier_segments dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points_if),
		.segments(segs_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Enter and leave at a falling edge.
	task automatic send_point(input logic [15:0] dx, input logic [15:0] dy, input logic last);
		s2b_point_t p;
		int         gap;
		p.delta_x    = dx;
		p.delta_y    = dy;
		p.last_point = last;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			points_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		points_if.delta_x    = p.delta_x;
		points_if.delta_y    = p.delta_y;
		points_if.last_point = p.last_point;
		points_if.valid      = 1'b1;
		do @(posedge clk); while (!points_if.ready);
		sb.note_point(p);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		points_if.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [15:0] random_delta();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 6)
			return 16'($urandom());
		if (mode < 8)
			return 16'($signed($urandom_range(0, 8)) - 4);
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			default: return 16'h0000;
		endcase
	endfunction

	task automatic send_spline(input int len);
		for (int i = 0; i < len; i++)
			send_point(random_delta(), random_delta(), i == len - 1);
	endtask

	// Sink side: while rx_idle is set, stall a random number of cycles before each item.
	initial begin
		int stall;
		segs_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				segs_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			segs_if.ready = 1'b1;
			do @(posedge clk); while (!segs_if.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		s2b_seg_t got;
		if (arst_n && segs_if.valid && segs_if.ready) begin
			got.ctrl1_x        = segs_if.ctrl1_x;
			got.ctrl1_y        = segs_if.ctrl1_y;
			got.ctrl2_x        = segs_if.ctrl2_x;
			got.ctrl2_y        = segs_if.ctrl2_y;
			got.end_x          = segs_if.end_x;
			got.end_y          = segs_if.end_y;
			got.too_few_points = segs_if.too_few_points;
			got.final_segment  = segs_if.final_segment;
			sb.check_segment(got);
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((points_if.valid && points_if.ready) || (segs_if.valid && segs_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		sb = new();
		items_sent           = 0;
		idle_cycles          = 0;
		tx_idle              = 1'b1;
		rx_idle              = 1'b1;
		arst_n               = 1'b0;
		points_if.valid      = 1'b0;
		points_if.delta_x    = '0;
		points_if.delta_y    = '0;
		points_if.last_point = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Single point splines.
		send_point(16'h0000, 16'h0000, 1'b1);
		send_point(16'h8000, 16'h7fff, 1'b1);
		// Two point curves, extremes and odd negatives for truncation.
		send_point(16'h7fff, 16'h8000, 1'b0);
		send_point(16'h8000, 16'h7fff, 1'b1);
		send_point(16'hfffd, 16'hfffb, 1'b0);
		send_point(16'hffff, 16'h0002, 1'b1);
		// Three and four point splines.
		send_point(16'h8000, 16'h8000, 1'b0);
		send_point(16'h7fff, 16'h7fff, 1'b0);
		send_point(16'hffff, 16'hffff, 1'b1);
		send_point(16'h0001, 16'hffff, 1'b0);
		send_point(16'hffff, 16'h0001, 1'b0);
		send_point(16'h0005, 16'hfff9, 1'b0);
		send_point(16'h0000, 16'h0000, 1'b1);
		// Back to back without idling.
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_point(16'h7fff, 16'h7fff, 1'b0);
		send_point(16'h7fff, 16'h8000, 1'b0);
		send_point(16'h8000, 16'h7fff, 1'b0);
		send_point(16'h8001, 16'h0003, 1'b1);
		wait_drained();

		// One long spline, then mostly short ones.
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_spline(150);
		while (items_sent < NUM_ITEMS) begin
			pick    = $urandom_range(0, 5);
			tx_idle = pick != 0 && pick != 2;
			rx_idle = pick != 0 && pick != 1;
			pick    = $urandom_range(0, 19);
			if (pick < 2)
				send_spline(1);
			else if (pick < 5)
				send_spline(2);
			else if (pick == 18)
				send_spline($urandom_range(20, 60));
			else
				send_spline($urandom_range(3, 8));
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_TAIL) @(negedge clk);
		if (sb.pending() != 0)
			sb.note_mismatch($sformatf("%0d segments never arrived", sb.pending()));
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
